>>> src/xcfr_pkg.sv
// Package for the XOR-checked frame receiver.
// Holds event codes, field widths and the shared structs; no dependencies.
package xcfr_pkg;

    localparam int ByteW   = 8;
    localparam int EventW  = 2;
    localparam int TotalW  = 9;
    localparam int PosW    = 9;
    localparam int CfgIdxW = 2;

    // Header bytes plus length byte that precede the payload.
    localparam logic [PosW-1:0] PrefixBytes  = 9'd3;
    // Header, length, checksum and end bytes around the payload.
    localparam logic [TotalW-1:0] FrameExtra = 9'd5;

    localparam logic [EventW-1:0] EvNone    = 2'd0;
    localparam logic [EventW-1:0] EvPayload = 2'd1;
    localparam logic [EventW-1:0] EvGood    = 2'd2;
    localparam logic [EventW-1:0] EvError   = 2'd3;

    localparam logic [CfgIdxW-1:0] RegHeaderFirst  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegHeaderSecond = 2'd1;
    localparam logic [CfgIdxW-1:0] RegEndMarker    = 2'd2;

    typedef struct packed {
        logic [ByteW-1:0] header_first;
        logic [ByteW-1:0] header_second;
        logic [ByteW-1:0] end_marker;
    } t_cfg;

    typedef struct packed {
        logic [EventW-1:0] event_res;
        logic [ByteW-1:0]  payload_data;
        logic [ByteW-1:0]  payload_index;
        logic [TotalW-1:0] frame_total;
    } t_result;

endpackage

>>> src/xcfr_parser.sv
// Frame parser state and the per-byte decision logic.
// Depends on xcfr_pkg for the event codes, widths and structs.
module xcfr_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [xcfr_pkg::ByteW-1:0]  i_byte,
    input  xcfr_pkg::t_cfg              i_cfg,
    output xcfr_pkg::t_result           o_result
);

    logic [xcfr_pkg::PosW-1:0]  r_position, n_position;
    logic [xcfr_pkg::ByteW-1:0] r_length, n_length;
    logic [xcfr_pkg::ByteW-1:0] r_xor, n_xor;
    logic [xcfr_pkg::ByteW-1:0] r_checksum, n_checksum;
    logic [xcfr_pkg::PosW-1:0]  payload_end;
    logic [xcfr_pkg::PosW-1:0]  pos_inc;
    logic [xcfr_pkg::PosW-1:0]  pos_off;

    assign payload_end = {1'b0, r_length} + xcfr_pkg::PrefixBytes;
    assign pos_inc     = r_position + 9'd1;
    assign pos_off     = r_position - xcfr_pkg::PrefixBytes;

    always_comb begin
        n_position = r_position;
        n_length   = r_length;
        n_xor      = r_xor;
        n_checksum = r_checksum;
        o_result   = '0;
        if (r_position == 9'd0) begin
            if (i_byte != i_cfg.header_first) begin
                o_result.event_res = xcfr_pkg::EvError;
                n_xor = '0;
            end else begin
                n_position = 9'd1;
            end
        end else if (r_position == 9'd1) begin
            if (i_byte != i_cfg.header_second) begin
                o_result.event_res = xcfr_pkg::EvError;
                n_position = '0;
                n_xor = '0;
            end else begin
                n_position = 9'd2;
            end
        end else if (r_position == 9'd2) begin
            n_length   = i_byte;
            n_xor      = i_byte;
            n_position = xcfr_pkg::PrefixBytes;
        end else if (r_position < payload_end) begin
            o_result.event_res     = xcfr_pkg::EvPayload;
            o_result.payload_data  = i_byte;
            o_result.payload_index = pos_off[xcfr_pkg::ByteW-1:0];
            n_xor      = r_xor ^ i_byte;
            n_position = pos_inc;
        end else if (r_position == payload_end) begin
            n_checksum = i_byte;
            n_position = pos_inc;
        end else begin
            // End byte: checked together with the stored checksum.
            if (i_byte != i_cfg.end_marker || r_checksum != r_xor) begin
                o_result.event_res = xcfr_pkg::EvError;
            end else begin
                o_result.event_res   = xcfr_pkg::EvGood;
                o_result.frame_total = {1'b0, r_length} + xcfr_pkg::FrameExtra;
            end
            n_position = '0;
            n_xor      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_length   <= '0;
            r_xor      <= '0;
            r_checksum <= '0;
        end else if (i_step) begin
            r_position <= n_position;
            r_length   <= n_length;
            r_xor      <= n_xor;
            r_checksum <= n_checksum;
        end
    end

`ifndef SYNTHESIS
    // The position never runs past the end byte of the current frame.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= {1'b0, r_length} + xcfr_pkg::FrameExtra - 9'd1)
        else $error("parser position beyond frame end");

    // A good frame always sends the parser back to idle (as does an error; only the good case is checked).
    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (o_result.event_res == xcfr_pkg::EvGood) |=> r_position == 9'd0)
        else $error("parser not idle after good frame");

    // Outside a frame the running checksum is cleared.
    a_xor_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position == 9'd0 |-> r_xor == '0)
        else $error("running checksum not cleared while idle");
`endif

endmodule

>>> src/xor_checked_frame_receiver_top.sv
// An accepted byte goes into the input register, is parsed from there into the result
// register, and waits in the input register while the receiver still holds the result.
// Throughput: one byte per cycle while results are taken; the input and result registers
// form a two-stage pipeline that advances whenever the result register is free or taken.
// Reset (i_rst_n low, synchronous) empties both stages, idles the parser and
// clears the three configuration registers to zero. Depends on xcfr_pkg and xcfr_parser.
module xor_checked_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Byte stream in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    // Result stream out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] payload_data, [15:8] payload_index,
                                         // [24:16] frame_total, [31:25] zero
    output logic [1:0]  m_axis_tuser     // [1:0] event_res
);

    xcfr_pkg::t_cfg    r_cfg;
    xcfr_pkg::t_result parse_res;
    xcfr_pkg::t_result r_res;
    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_out_vld;
    logic              advance;

    // Configuration is always taken; writes to the unused index are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                xcfr_pkg::RegHeaderFirst:  r_cfg.header_first  <= i_cfg_data;
                xcfr_pkg::RegHeaderSecond: r_cfg.header_second <= i_cfg_data;
                xcfr_pkg::RegEndMarker:    r_cfg.end_marker    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The second stage moves whenever the result register is empty or being drained.
    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // The parser state steps only when the buffered byte moves into the result register.
    xcfr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_vld && advance),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_res <= parse_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_res.event_res;
    assign m_axis_tdata  = {7'd0, r_res.frame_total, r_res.payload_index,
                            r_res.payload_data};

`ifndef SYNTHESIS
    // Only a payload event carries payload data or an index.
    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != xcfr_pkg::EvPayload) |-> m_axis_tdata[15:0] == '0)
        else $error("payload fields set on a non-payload event");

    // Only a good-frame event carries a frame size, and it is at least five.
    a_total_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == xcfr_pkg::EvGood) ?
            (m_axis_tdata[24:16] >= xcfr_pkg::FrameExtra) : (m_axis_tdata[24:16] == '0)))
        else $error("frame size field inconsistent with event");

    // A stalled input stage holds the byte while the output is blocked.
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_byte))
        else $error("buffered byte lost during stall");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for xor_checked_frame_receiver_top: framed byte streams in,
// one event per byte out, checked against a predictor kept in a small class.
// Depends on xcfr_pkg and the receiver RTL; needs no files or arguments.
module testbench;

    // Register index that decodes to no register; writes to it must be dropped.
    localparam logic [xcfr_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
    localparam int unsigned RandomItems = 1050;

    typedef enum {FrGood, FrBadSum, FrBadEnd, FrBadSecond, FrNoise} t_frame_kind;

    // Parser prediction and result checking. accept_byte runs the frame parser
    // for one accepted byte and queues the event it must produce;
    // check_event compares one delivered result against the oldest entry.
    class t_frame_event_scoreboard;
        logic [xcfr_pkg::ByteW-1:0] hdr_first, hdr_second, end_byte;
        logic [xcfr_pkg::PosW-1:0]  pos;
        logic [xcfr_pkg::ByteW-1:0] frame_len, xor_acc, rx_csum;
        xcfr_pkg::t_result          expected_events[$];
        int                         errors;

        function new();
            hdr_first = '0; hdr_second = '0; end_byte = '0;
            pos = '0; frame_len = '0; xor_acc = '0; rx_csum = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [xcfr_pkg::CfgIdxW-1:0] idx,
                                logic [xcfr_pkg::ByteW-1:0] value);
            case (idx)
                xcfr_pkg::RegHeaderFirst:  hdr_first  = value;
                xcfr_pkg::RegHeaderSecond: hdr_second = value;
                xcfr_pkg::RegEndMarker:    end_byte   = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void accept_byte(logic [xcfr_pkg::ByteW-1:0] b);
            xcfr_pkg::t_result          ev;
            logic [xcfr_pkg::PosW-1:0]  payload_end;
            logic [xcfr_pkg::PosW-1:0]  idx_full;
            ev = '0;
            payload_end = {1'b0, frame_len} + xcfr_pkg::PrefixBytes;
            idx_full = pos - xcfr_pkg::PrefixBytes;
            if (pos == 9'd0) begin
                if (b != hdr_first) ev.event_res = xcfr_pkg::EvError;
                else pos = 9'd1;
            end else if (pos == 9'd1) begin
                if (b != hdr_second) begin
                    ev.event_res = xcfr_pkg::EvError;
                    pos = 9'd0;
                    xor_acc = '0;
                end else begin
                    pos = 9'd2;
                end
            end else if (pos == 9'd2) begin
                frame_len = b;
                xor_acc = b;
                pos = xcfr_pkg::PrefixBytes;
            end else if (pos < payload_end) begin
                ev.event_res = xcfr_pkg::EvPayload;
                ev.payload_data = b;
                ev.payload_index = idx_full[xcfr_pkg::ByteW-1:0];
                xor_acc = xor_acc ^ b;
                pos = pos + 9'd1;
            end else if (pos == payload_end) begin
                rx_csum = b;
                pos = pos + 9'd1;
            end else begin
                // A wrong end byte is an error on its own; the checksum only matters when the end byte is right.
                if (b != end_byte || rx_csum != xor_acc) begin
                    ev.event_res = xcfr_pkg::EvError;
                end else begin
                    ev.event_res = xcfr_pkg::EvGood;
                    ev.frame_total = {1'b0, frame_len} + xcfr_pkg::FrameExtra;
                end
                pos = 9'd0;
                xor_acc = '0;
            end
            expected_events.push_back(ev);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        function void check_event(logic [31:0] data, logic [xcfr_pkg::EventW-1:0] user);
            xcfr_pkg::t_result want;
            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending, expected none, %s %0h data %0h",
                         $time, "actual event", user, data);
                return;
            end
            want = expected_events.pop_front();
            if (user !== want.event_res)
                report("event_res", 32'(want.event_res), 32'(user));
            if (data[7:0] !== want.payload_data)
                report("payload_data", 32'(want.payload_data), 32'(data[7:0]));
            if (data[15:8] !== want.payload_index)
                report("payload_index", 32'(want.payload_index), 32'(data[15:8]));
            if (data[24:16] !== want.frame_total)
                report("frame_total", 32'(want.frame_total), 32'(data[24:16]));
            if (data[31:25] !== '0)
                report("tdata padding", 32'd0, 32'(data[31:25]));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [7:0]        i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;    // [7:0] rx_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;    // [7:0] payload_data, [15:8] payload_index,
                                        // [24:16] frame_total, [31:25] zero
    logic [1:0]        m_axis_tuser;    // [1:0] event_res

    t_frame_event_scoreboard sb;

    // Idling controls: when a flag is clear that side runs at full rate.
    bit          src_idle_on;
    bit          sink_idle_on;
    int          sink_stall;
    int unsigned bytes_sent;

    xor_checked_frame_receiver_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs. The slowest legal run (every byte
    // hitting a long sender gap and a long receiver stall) is well under a
    // fifth of this.
    initial begin
        #8_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Both handshakes are observed with the values seen just before the edge,
    // so every transaction is counted exactly once no matter the event order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.accept_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_event(m_axis_tdata, m_axis_tuser);
        end
    end

    // Receiver side back-pressure.
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if (sink_idle_on && $urandom_range(0, 99) < 25) begin
            m_axis_tready <= 1'b0;
            sink_stall <= pick_gap(1'b1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // One byte transaction, optionally preceded by a gap. tvalid stays high
    // between back-to-back bytes, so it is only lowered when a gap is taken.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Stop sending and wait until every queued event has been delivered. The
    // first edge lets the monitor record a byte accepted at the last edge.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Writes the three registers (and, if asked, the unused index) while the
    // block is idle. cfg_valid stays high across the back-to-back writes.
    task automatic configure(input logic [7:0] h1, h2, e, input bit touch_unused);
        logic [xcfr_pkg::CfgIdxW-1:0] regs [4] = '{xcfr_pkg::RegHeaderFirst,
                                                   xcfr_pkg::RegHeaderSecond,
                                                   xcfr_pkg::RegEndMarker, RegUnused};
        logic [7:0]                   vals [4];
        int                           n;
        vals = '{h1, h2, e, 8'($urandom)};
        n = touch_unused ? 4 : 3;
        drain();
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(regs[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] nonzero_flip();
        return 8'($urandom_range(1, 255));
    endfunction

    // Mostly short payloads; a few long ones to exercise the wide counters.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 8);
        if (r < 97) return $urandom_range(9, 40);
        return $urandom_range(41, 255);
    endfunction

    function automatic t_frame_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return FrGood;
        if (r < 78) return FrBadSum;
        if (r < 86) return FrBadEnd;
        if (r < 93) return FrBadSecond;
        return FrNoise;
    endfunction

    // Sends one frame built from the current register settings, broken in the
    // way the kind asks. A bad end byte sometimes comes with a bad checksum too,
    // since a wrong end byte is an error whatever the checksum.
    task automatic send_frame(input t_frame_kind kind, input int len);
        logic [7:0] csum;
        logic [7:0] b;
        int         n;
        if (kind == FrNoise) begin
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'($urandom));
            return;
        end
        push_byte(sb.hdr_first);
        if (kind == FrBadSecond) begin
            push_byte(sb.hdr_second ^ nonzero_flip());
            return;
        end
        push_byte(sb.hdr_second);
        push_byte(8'(len));
        csum = 8'(len);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            csum ^= b;
            push_byte(b);
        end
        if (kind == FrBadSum || (kind == FrBadEnd && $urandom_range(0, 1) == 1))
            push_byte(csum ^ nonzero_flip());
        else
            push_byte(csum);
        push_byte(kind == FrBadEnd ? sb.end_byte ^ nonzero_flip() : sb.end_byte);
    endtask

    initial begin
        int phase;
        int frames;
        sb = new();
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        sink_stall = 0;
        bytes_sent = 0;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= xcfr_pkg::RegHeaderFirst;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, full rate on both sides.
        // Registers are still at reset: an all-zero frame with zero length is
        // good, and its checksum is the length byte itself.
        repeat (5) push_byte(8'h00);

        configure(8'hA5, 8'h5A, 8'h7E, 1'b1);
        // An idle byte that is not the first header byte is an error on its own.
        push_byte(8'h00);
        push_byte(8'hFF);
        // Wrong second header byte; that byte equals the first header value but
        // is not taken as a new start, so the following 5A is an error as well.
        push_byte(8'hA5);
        push_byte(8'hA5);
        push_byte(8'h5A);
        // A good empty frame, then a good two-byte frame with the payload extremes.
        send_frame(FrGood, 0);
        push_byte(8'hA5); push_byte(8'h5A); push_byte(8'h02);
        push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFD); push_byte(8'h7E);
        // Wrong end byte while the checksum is also wrong.
        push_byte(8'hA5); push_byte(8'h5A); push_byte(8'h01);
        push_byte(8'h33); push_byte(8'h00); push_byte(8'h00);
        // Checksum mismatch behind a correct end byte.
        push_byte(8'hA5); push_byte(8'h5A); push_byte(8'h00);
        push_byte(8'h01); push_byte(8'h7E);

        // Random part, one register setting per phase. The first phases cover
        // the register extremes, and phase 2 carries the longest frame.
        phase = 0;
        while (bytes_sent < RandomItems) begin
            case (phase)
                0: configure(8'hFF, 8'hFF, 8'hFF, 1'b1);
                1: configure(8'h00, 8'h00, 8'h00, 1'b1);
                default: configure(8'($urandom), 8'($urandom), 8'($urandom),
                                   $urandom_range(0, 1) == 1);
            endcase
            // The first phase runs with no idling at all; later ones mostly idle.
            src_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            sink_idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            if (phase == 2) send_frame(FrGood, 255);
            frames = 0;
            while (frames < 12 && bytes_sent < RandomItems) begin
                send_frame(pick_kind(), pick_len());
                // Occasionally hold the sender until the output side catches up.
                if ($urandom_range(0, 29) == 0) drain();
                frames++;
            end
            phase++;
        end

        drain();
        // Keep the clock running so that a stray extra result would still be seen.
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
